// ----- rtl/per_source_message_rate_limiter_core_defines.svh -----
// Assertion macros shared by the rate limiter checker.
// No dependencies; include by bare file name.
`ifndef PER_SOURCE_MESSAGE_RATE_LIMITER_CORE_DEFINES_SVH
`define PER_SOURCE_MESSAGE_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low
`define PSRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low
`define PSRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/psrl_pkg.sv -----
// Shared types and constants of the per-source message rate limiter.
// No dependencies; used by the core and by its checker.
package psrl_pkg;

    // Field widths
    localparam int unsigned SRC_W     = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned IN_DATA_W = 48;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned PDATA_W   = 32;

    // Defaults and fixed policy
    localparam int unsigned DEF_SOURCES  = 1024;
    localparam int unsigned RESTART_WAIT = 600;
    localparam int unsigned DIV_STEPS    = 32;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_PASS     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_WARN     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SUPPRESS = 2'd2;

    // Opcodes
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register word index (paddr[3:2])
    localparam logic [1:0] REG_RATE_LIMIT = 2'd0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_DECIDE,
        ST_WRITE,
        ST_SWEEP,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/per_source_message_rate_limiter_core.sv -----
// Per-source message rate limiter core: source table, serial divider, control.
// Depends on psrl_pkg.
//
// Rate limiter over fixed one-second windows for up to SOURCES message sources.
// Each input word names a source and the current second and yields one verdict
// word: pass, pass with excess warning (source enters shutdown) or suppress.
// After reset a clearing pass writes every table entry, one per cycle, with
// s_axis_tready held low until it ends. A message word then runs the read,
// evaluate, write and done states; a shut-down source that sees a new second
// adds divide and decide states before write, a re-check by a restoring
// divider that retires one quotient bit per cycle. A clear word walks the
// shutdown marks one per cycle. One word is in work at a time; a new word is
// taken while the previous verdict still waits in the output register.
// rate_limit is at APB address 0; zero passes every message untouched.
module per_source_message_rate_limiter_core #(
    parameter int unsigned SOURCES = psrl_pkg::DEF_SOURCES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: tdata = source_index[9:0], now_seconds[41:10], zero pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [psrl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser = opcode[0]
    input  logic                               s_axis_tuser,
    // master side: tdata = verdict[1:0], zero pad
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [psrl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psrl_pkg::ADDR_W-1:0]        paddr,
    input  logic [psrl_pkg::PDATA_W-1:0]       pwdata,
    output logic [psrl_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import psrl_pkg::*;

    localparam int unsigned AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SOURCES - 1);
    localparam logic [16:0] SRC_LIMIT = 17'(SOURCES);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);
    localparam logic [TIME_W-1:0] WAIT_SEC = TIME_W'(RESTART_WAIT);
    localparam int unsigned ENT_W = 3 * TIME_W;

    // Control
    t_state r_state, n_state;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [4:0]    r_div_cnt, n_div_cnt;
    logic          r_out_valid, n_out_valid;
    logic [RATE_W-1:0] r_rate;

    // Item and working payload
    logic [SRC_W-1:0]     r_src, n_src;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [VERDICT_W-1:0] r_verdict, n_verdict;
    logic [VERDICT_W-1:0] r_out_verdict, n_out_verdict;
    logic [TIME_W-1:0]    r_wr_last, n_wr_last;
    logic [TIME_W-1:0]    r_wr_start, n_wr_start;
    logic [TIME_W-1:0]    r_wr_count, n_wr_count;
    logic                 r_wr_mark, n_wr_mark;

    // Serial divider: remainder, dividend/quotient shift register, divisor
    logic [TIME_W:0]      r_div_rem, n_div_rem;
    logic [TIME_W-1:0]    r_div_quo, n_div_quo;
    logic [TIME_W-1:0]    r_div_dsr, n_div_dsr;

    // Source table
    logic [ENT_W-1:0] r_mem_ent  [SOURCES];
    logic             r_mem_mark [SOURCES];
    logic [ENT_W-1:0] r_rd_ent;
    logic             r_rd_mark;

    logic [16:0]      w_in_src_ext;
    logic [AW-1:0]    w_addr;
    logic             w_in_acc;
    logic             w_in_range;
    logic             w_cfg_wr;
    logic [TIME_W-1:0] w_ent_last, w_ent_start, w_ent_count, w_cnt_inc, w_elapsed;
    logic [TIME_W:0]  w_rem_sh;
    logic             w_rem_ge;

    assign w_in_src_ext = {7'b0, s_axis_tdata[SRC_W-1:0]};
    assign w_addr       = AW'(r_src);
    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_in_range   = (w_in_src_ext < SRC_LIMIT);

    assign w_ent_last  = r_rd_ent[TIME_W-1:0];
    assign w_ent_start = r_rd_ent[2*TIME_W-1:TIME_W];
    assign w_ent_count = r_rd_ent[3*TIME_W-1:2*TIME_W];
    assign w_cnt_inc   = (w_ent_count == '1) ? w_ent_count : w_ent_count + 1'b1;
    assign w_elapsed   = r_now - w_ent_start;

    // One divider step: shift in the next dividend bit, try the subtract
    assign w_rem_sh = {r_div_rem[TIME_W-1:0], r_div_quo[TIME_W-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_div_dsr});

    // Stream and APB outputs
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - VERDICT_W){1'b0}}, r_out_verdict};
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign prdata        = (paddr[3:2] == REG_RATE_LIMIT) ?
                           {{(PDATA_W - RATE_W){1'b0}}, r_rate} : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_sweep == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_CLEAR) n_state = ST_SWEEP;
                    else if (r_rate != '0 && w_in_range) n_state = ST_READ;
                    else n_state = ST_DONE;
                end
            end
            ST_READ:   n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_rd_mark && w_ent_last != r_now) n_state = ST_DIV;
                else n_state = ST_WRITE;
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_LAST) n_state = ST_DECIDE;
            end
            ST_DECIDE: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_DONE;
            ST_SWEEP: begin
                if (r_sweep == LAST_ADDR) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default:   n_state = ST_INIT;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_sweep       = r_sweep;
        n_div_cnt     = r_div_cnt;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_src         = r_src;
        n_now         = r_now;
        n_verdict     = r_verdict;
        n_wr_last     = r_wr_last;
        n_wr_start    = r_wr_start;
        n_wr_count    = r_wr_count;
        n_wr_mark     = r_wr_mark;
        n_div_rem     = r_div_rem;
        n_div_quo     = r_div_quo;
        n_div_dsr     = r_div_dsr;

        // drop the verdict once taken
        if (r_out_valid && m_axis_tready) n_out_valid = 1'b0;

        case (r_state)
            ST_INIT, ST_SWEEP: begin
                n_sweep = (r_sweep == LAST_ADDR) ? '0 : r_sweep + 1'b1;
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_src     = s_axis_tdata[SRC_W-1:0];
                    n_now     = s_axis_tdata[SRC_W+TIME_W-1:SRC_W];
                    n_verdict = VERDICT_PASS;
                end
            end
            ST_EVAL: begin
                n_wr_last  = w_ent_last;
                n_wr_start = w_ent_start;
                n_wr_count = w_cnt_inc;
                n_wr_mark  = r_rd_mark;
                if (r_rd_mark) begin
                    if (w_ent_last == r_now) begin
                        n_verdict = VERDICT_SUPPRESS;
                    end else begin
                        // new second in shutdown: load divider with count / elapsed
                        n_wr_last  = r_now;
                        n_wr_count = TIME_W'(1);
                        n_div_rem  = '0;
                        n_div_quo  = w_cnt_inc;
                        n_div_dsr  = w_elapsed;
                        n_div_cnt  = '0;
                    end
                end else if (w_ent_last == r_now) begin
                    if (w_cnt_inc > {{(TIME_W - RATE_W){1'b0}}, r_rate}) begin
                        n_wr_mark  = 1'b1;
                        n_wr_start = r_now;
                        n_verdict  = VERDICT_WARN;
                    end
                end else begin
                    n_wr_last  = r_now;
                    n_wr_count = TIME_W'(1);
                end
            end
            ST_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                n_div_rem = w_rem_ge ? (w_rem_sh - {1'b0, r_div_dsr}) : w_rem_sh;
                n_div_quo = {r_div_quo[TIME_W-2:0], w_rem_ge};
            end
            ST_DECIDE: begin
                // zero elapsed gives an all-ones quotient, so it restarts
                if (r_div_quo > {{(TIME_W - RATE_W){1'b0}}, r_rate}) begin
                    n_wr_start = r_now;
                    n_verdict  = VERDICT_SUPPRESS;
                end else if (r_div_dsr >= WAIT_SEC) begin
                    n_wr_mark  = 1'b0;
                    n_verdict  = VERDICT_PASS;
                end else begin
                    n_verdict  = VERDICT_SUPPRESS;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= '0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && paddr[3:2] == REG_RATE_LIMIT) r_rate <= pwdata[RATE_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src         <= n_src;
        r_now         <= n_now;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_wr_last     <= n_wr_last;
        r_wr_start    <= n_wr_start;
        r_wr_count    <= n_wr_count;
        r_wr_mark     <= n_wr_mark;
        r_div_rem     <= n_div_rem;
        r_div_quo     <= n_div_quo;
        r_div_dsr     <= n_div_dsr;
    end

    // Source table: clear pass, mark sweep, write back, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INIT) begin
            r_mem_ent[r_sweep]  <= '0;
            r_mem_mark[r_sweep] <= 1'b0;
        end else if (r_state == ST_SWEEP) begin
            r_mem_mark[r_sweep] <= 1'b0;
        end else if (r_state == ST_WRITE) begin
            r_mem_ent[w_addr]  <= {r_wr_count, r_wr_start, r_wr_last};
            r_mem_mark[w_addr] <= r_wr_mark;
        end
        if (r_state == ST_READ) begin
            r_rd_ent  <= r_mem_ent[w_addr];
            r_rd_mark <= r_mem_mark[w_addr];
        end
    end

endmodule

// ----- rtl/psrl_checker.sv -----
// Port-level checker for the per-source message rate limiter core.
// Depends on psrl_pkg and per_source_message_rate_limiter_core_defines.svh.
`include "per_source_message_rate_limiter_core_defines.svh"

module psrl_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata = verdict[1:0], zero pad
    input  logic [psrl_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import psrl_pkg::*;

    logic [1:0] r_pending, n_pending;
    logic       w_in_acc, w_out_acc;
    logic       w_out_stall;
    logic       w_code_ok;
    logic [VERDICT_W-1:0] w_verdict;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_acc   = m_axis_tvalid && m_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_verdict   = m_axis_tdata[VERDICT_W-1:0];
    assign w_code_ok   = (w_verdict == VERDICT_PASS) || (w_verdict == VERDICT_WARN) ||
                         (w_verdict == VERDICT_SUPPRESS);

    // Track words accepted but not yet delivered
    always_comb begin
        n_pending = r_pending + {1'b0, w_in_acc} - {1'b0, w_out_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `PSRL_ASSERT_NOW(a_out_has_owner, m_axis_tvalid, r_pending != 2'd0, "verdict with no word")
    `PSRL_ASSERT_NOW(a_pending_bound, 1'b1, r_pending != 2'd3, "over two words in flight")
    `PSRL_ASSERT_NOW(a_verdict_code, m_axis_tvalid, w_code_ok, "undefined verdict code")
    `PSRL_ASSERT_NOW(a_clear_pass, $rose(i_rst_n), !s_axis_tready, "input taken while clearing")
    `PSRL_ASSERT_NEXT(a_out_hold, w_out_stall, m_axis_tvalid && $stable(m_axis_tdata), "verdict moved")

endmodule

bind per_source_message_rate_limiter_core psrl_checker u_psrl_checker (.*);
